### src/sincos_argument_reduction_defines.svh
// assertion macros shared by the rtl
`ifndef SINCOS_ARGUMENT_REDUCTION_DEFINES_SVH
`define SINCOS_ARGUMENT_REDUCTION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SAR_ASSERT_NOW(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("sar assertion failed");

// next-cycle implication, disabled during reset
`define SAR_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("sar assertion failed");

`endif

### src/sar_pkg.sv
package sar_pkg;

  localparam int SIG_W   = 24;
  localparam int WORD_W  = 32;
  localparam int NWORDS  = 8;
  localparam int PP_W    = SIG_W + WORD_W;
  localparam int PROD_W  = (NWORDS + 1) * WORD_W;
  localparam int HALF_W  = PROD_W / 2;
  localparam int EXT_W   = PROD_W + WORD_W;
  localparam int FRAC_W  = 64;
  localparam int QUAD_W  = 2;
  localparam int POS_W   = 8;
  localparam int EXP_W   = 8;

  localparam int MUL_STAGES = 4;
  localparam int EXT_STAGES = 2;
  localparam int NUM_STAGES = MUL_STAGES + EXT_STAGES;

  localparam logic [EXP_W-1:0]  EXP_MIN     = 8'd126;
  localparam logic [EXP_W-1:0]  EXP_MAX     = 8'd254;
  localparam logic [8:0]        POS_BASE    = 9'd342;
  localparam logic [30:0]       SMALL_LIMIT = 31'h3f490fdb;
  localparam logic [30:0]       TINY_LIMIT  = 31'h39800000;
  localparam logic [30:0]       INF_BITS    = 31'h7f800000;
  localparam logic [SIG_W-1:0]  HIDDEN_ONE  = 24'h800000;

  // floor((2/pi) * 2^256), least significant word at index 0
  localparam logic [NWORDS-1:0][WORD_W-1:0] PHASE_CONST = '{
    32'ha2f9836e, 32'h4e441529, 32'hfc2757d1, 32'hf534ddc0,
    32'hdb629599, 32'h3c439041, 32'hfe5163ab, 32'hdebbc561
  };

  typedef enum logic {
    OP_SINE   = 1'b0,
    OP_COSINE = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             sign;
    logic             is_small;
    logic             tiny;
    logic             nonfinite;
    logic [POS_W-1:0] pos;
  } side_t;

endpackage

### src/sar_multiply.sv
module sar_multiply (
  input  logic                               clk,
  input  logic [sar_pkg::MUL_STAGES-1:0]     advance,
  input  logic                               opcode,
  input  logic [31:0]                        value,
  output logic [sar_pkg::PROD_W-1:0]         prod,
  output sar_pkg::side_t                     side
);
  import sar_pkg::*;

  logic [30:0]       ax;
  logic [EXP_W-1:0]  exp_raw;
  logic [EXP_W-1:0]  exp_clamp;
  logic [8:0]        pos_wide;
  side_t             side_next;

  logic [SIG_W-1:0]  sig;
  side_t             side1;
  logic [PP_W-1:0]   pp [NWORDS];
  side_t             side2;
  logic [PROD_W-1:0] even_sum;
  logic [PROD_W-1:0] odd_sum;
  logic [HALF_W:0]   low_sum;
  logic [HALF_W-1:0] lo;
  logic              carry;
  logic [HALF_W-1:0] even_hi;
  logic [HALF_W-1:0] odd_hi;
  side_t             side3;

  // stage 1: significand, flags and window position
  always_comb begin
    ax        = value[30:0];
    exp_raw   = ax[30:23];
    exp_clamp = exp_raw;
    if (exp_raw < EXP_MIN) begin
      exp_clamp = EXP_MIN;
    end
    if (exp_raw > EXP_MAX) begin
      exp_clamp = EXP_MAX;
    end
    pos_wide            = POS_BASE - {1'b0, exp_clamp};
    side_next.op        = op_t'(opcode);
    side_next.sign      = value[31];
    side_next.is_small  = ax < SMALL_LIMIT;
    side_next.tiny      = ax < TINY_LIMIT;
    side_next.nonfinite = ax >= INF_BITS;
    side_next.pos       = pos_wide[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (advance[0]) begin
      sig   <= {1'b0, ax[22:0]} | HIDDEN_ONE;
      side1 <= side_next;
    end
  end

  // stage 2: one 24x32 partial product per constant word
  always_ff @(posedge clk) begin
    if (advance[1]) begin
      for (int i = 0; i < NWORDS; i++) begin
        pp[i] <= PP_W'(sig) * PP_W'(PHASE_CONST[i]);
      end
      side2 <= side1;
    end
  end

  // even and odd words land without overlap
  always_comb begin
    even_sum = '0;
    odd_sum  = '0;
    for (int i = 0; i < NWORDS; i++) begin
      if (i % 2 == 0) begin
        even_sum[i*WORD_W +: PP_W] = pp[i];
      end else begin
        odd_sum[i*WORD_W +: PP_W] = pp[i];
      end
    end
    low_sum = {1'b0, even_sum[HALF_W-1:0]} + {1'b0, odd_sum[HALF_W-1:0]};
  end

  // stage 3: lower half add
  always_ff @(posedge clk) begin
    if (advance[2]) begin
      lo      <= low_sum[HALF_W-1:0];
      carry   <= low_sum[HALF_W];
      even_hi <= even_sum[PROD_W-1:HALF_W];
      odd_hi  <= odd_sum[PROD_W-1:HALF_W];
      side3   <= side2;
    end
  end

  // stage 4: upper half add with carry
  always_ff @(posedge clk) begin
    if (advance[3]) begin
      prod <= {even_hi + odd_hi + HALF_W'(carry), lo};
      side <= side3;
    end
  end

endmodule

### src/sar_extract.sv
module sar_extract (
  input  logic                               clk,
  input  logic [sar_pkg::EXT_STAGES-1:0]     advance,
  input  logic [sar_pkg::PROD_W-1:0]         prod,
  input  sar_pkg::side_t                     side,
  output logic [sar_pkg::QUAD_W-1:0]         quadrant,
  output logic [sar_pkg::FRAC_W-1:0]         fraction,
  output logic                               rounded_up,
  output logic                               small_argument,
  output logic                               tiny_argument,
  output logic                               not_finite,
  output logic                               input_sign
);
  import sar_pkg::*;

  logic [EXT_W-1:0]  window;
  logic [FRAC_W-1:0] frac;
  logic [QUAD_W-1:0] quad;
  side_t             side5;

  logic              neg;
  logic [QUAD_W-1:0] quad_next;
  logic [FRAC_W-1:0] frac_next;
  logic              neg_next;

  // stage 5: funnel the 66-bit quadrant and fraction window out of the product
  assign window = {{WORD_W{1'b0}}, prod} >> side.pos;

  always_ff @(posedge clk) begin
    if (advance[0]) begin
      frac  <= window[FRAC_W-1:0];
      quad  <= window[FRAC_W +: QUAD_W];
      side5 <= side;
    end
  end

  // stage 6: round to nearest quadrant, apply special cases
  always_comb begin
    neg       = frac[FRAC_W-1];
    quad_next = quad + QUAD_W'(neg);
    frac_next = neg ? (~frac + FRAC_W'(1)) : frac;
    neg_next  = neg;
    if (side5.is_small) begin
      quad_next = '0;
      frac_next = '0;
      neg_next  = 1'b0;
    end
    if (side5.op == OP_COSINE) begin
      quad_next = quad_next + QUAD_W'(1);
    end
    if (side5.nonfinite) begin
      quad_next = '0;
      frac_next = '0;
      neg_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance[1]) begin
      quadrant       <= quad_next;
      fraction       <= frac_next;
      rounded_up     <= neg_next;
      small_argument <= side5.is_small;
      tiny_argument  <= side5.tiny;
      not_finite     <= side5.nonfinite;
      input_sign     <= side5.sign;
    end
  end

endmodule

### src/sincos_argument_reduction.sv
// channel   handshake               fields
// input     in_valid / in_stall     opcode, value
// output    out_valid / out_stall   quadrant, fraction, rounded_up, small_argument,
//                                   tiny_argument, not_finite, input_sign
//
// six register stages; one transaction per cycle sustained while out_stall is low
// the eight partial-product multipliers and the two 144-bit half adds set the stage depth
// synchronous reset clears only the stage valid bits
// each stage holds while the one after it is full and held, so bubbles fill under a stall
// in_stall follows out_stall combinationally only when every stage is full
module sincos_argument_reduction (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [31:0]                    value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sar_pkg::QUAD_W-1:0]     quadrant,
  output logic [sar_pkg::FRAC_W-1:0]     fraction,
  output logic                           rounded_up,
  output logic                           small_argument,
  output logic                           tiny_argument,
  output logic                           not_finite,
  output logic                           input_sign
);
  import sar_pkg::*;
  `include "sincos_argument_reduction_defines.svh"

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] advance;
  logic [PROD_W-1:0]     prod;
  side_t                 side;

  always_comb begin
    advance[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      advance[k] = !stage_valid[k] || advance[k+1];
    end
  end

  assign in_stall  = !advance[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (advance[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (advance[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  sar_multiply u_multiply (
    .clk     (clk),
    .advance (advance[MUL_STAGES-1:0]),
    .opcode  (opcode),
    .value   (value),
    .prod    (prod),
    .side    (side)
  );

  sar_extract u_extract (
    .clk            (clk),
    .advance        (advance[NUM_STAGES-1:MUL_STAGES]),
    .prod           (prod),
    .side           (side),
    .quadrant       (quadrant),
    .fraction       (fraction),
    .rounded_up     (rounded_up),
    .small_argument (small_argument),
    .tiny_argument  (tiny_argument),
    .not_finite     (not_finite),
    .input_sign     (input_sign)
  );

  // an accepted transaction always occupies the first stage next cycle
  `SAR_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && !in_stall, stage_valid[0])
  // tiny arguments are a subset of small ones
  `SAR_ASSERT_NOW(a_tiny_small, clk, rst, out_valid && tiny_argument, small_argument)
  // non-finite inputs clear the reduction result
  `SAR_ASSERT_NOW(a_nonfinite_zero, clk, rst, out_valid && not_finite,
    quadrant == '0 && fraction == '0 && !rounded_up)
  // rounding only happens on the reduction path
  `SAR_ASSERT_NOW(a_round_path, clk, rst, out_valid && rounded_up,
    !small_argument && !not_finite)

endmodule
